/* rtl/core/swld_pkg.sv */
// Shared constants, types and widths for the sliding-window slope estimator.
// Used by every module under rtl/core but swld_ram; depends on nothing else.
package swld_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int CHANNELS   = 4;
  localparam int SLOT_W     = $clog2(MAX_WINDOW);
  localparam int LEN_W      = 4;
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int SLOPE_W    = 32;
  localparam int ROW_W      = CHANNELS * SAMPLE_W;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_WINDOW);

  // Microseconds to seconds (1e6) times four, from 14 to 16 fraction bits.
  localparam int K_W = 22;
  localparam logic [K_W-1:0] SLOPE_SCALE = K_W'(4000000);

  // Accumulator and divider widths.
  localparam int SQ_W   = 2 * TIME_W;
  localparam int PR_W   = TIME_W + 1 + SAMPLE_W + 1;
  localparam int DEN_W  = SQ_W + 6;
  localparam int NUM_W  = PR_W + 6;
  localparam int HALF_W = NUM_W / 2;
  localparam int PP_W   = HALF_W + K_W;
  localparam int PROD_W = NUM_W + K_W;
  localparam int REM_W  = PROD_W + 1;
  localparam int Q_W    = SLOPE_W + 1;
  localparam int DSH_W  = DEN_W + 1 + SLOPE_W;
  localparam int CNT_W  = $clog2(Q_W);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    JOB_BLANK,
    JOB_FIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t          kind;
    logic [SLOT_W-1:0]  oldest;
    logic [LEN_W-1:0]   len;
  } job_t;

endpackage

/* rtl/core/swld_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
// Self-contained; no package needed.
module swld_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/core/swld_queue.sv */
// Short job queue between front and back.
// Depends on swld_pkg for job_t and QUEUE_DEPTH.
module swld_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  swld_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output swld_pkg::job_t pop_data,
  output logic          empty
);
  import swld_pkg::*;

  localparam int Q_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t              entries [QUEUE_DEPTH];
  logic [Q_AW-1:0]   rd_ptr;
  logic [Q_AW-1:0]   wr_ptr;
  logic [Q_AW:0]     count;

  assign full     = (count == (Q_AW + 1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/swld_front.sv */
// Front end: takes input words and the window length, writes the rings and
// queues one job per word. Depends on swld_pkg.
module swld_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swld_pkg::LEN_W-1:0]        window_len,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              restart,
  input  logic [swld_pkg::TIME_W-1:0]       sample_time,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_3,
  input  logic                              q_full,
  output logic                              q_push,
  output swld_pkg::job_t                    q_data,
  input  logic                              fit_done,
  output logic                              ring_we,
  output logic [swld_pkg::SLOT_W-1:0]       ring_waddr,
  output logic [swld_pkg::TIME_W-1:0]       time_wdata,
  output logic [swld_pkg::ROW_W-1:0]        row_wdata,
  output logic [swld_pkg::MAX_WINDOW-1:0]   slot_valid
);
  import swld_pkg::*;

  logic [LEN_W-1:0]  len_reg;
  logic [SLOT_W-1:0] write_index;
  logic              window_full;
  logic              fit_busy;

  logic [LEN_W-1:0]  eff_len;
  logic [SLOT_W-1:0] slot;
  logic [LEN_W-1:0]  slot_inc;
  logic              wrap;
  logic [SLOT_W-1:0] index_next;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full && !fit_busy;
  assign accept    = in_valid && in_ready;

  always_comb begin
    if (len_reg < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (len_reg > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = len_reg;
    end
    slot       = (LEN_W'(write_index) >= eff_len) ? '0 : write_index;
    slot_inc   = LEN_W'(slot) + LEN_W'(1);
    wrap       = (slot_inc >= eff_len);
    index_next = wrap ? '0 : slot_inc[SLOT_W-1:0];
  end

  always_comb begin
    q_push        = accept;
    q_data.oldest = index_next;
    q_data.len    = eff_len;
    q_data.kind   = (!restart && (wrap || window_full)) ? JOB_FIT : JOB_BLANK;
  end

  assign ring_we    = accept && !restart;
  assign ring_waddr = slot;
  assign time_wdata = sample_time;
  assign row_wdata  = {sample_3, sample_2, sample_1, sample_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      len_reg     <= LEN_RESET;
      write_index <= '0;
      window_full <= 1'b0;
      slot_valid  <= '0;
      fit_busy    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        len_reg <= window_len;
      end
      if (accept) begin
        if (restart) begin
          write_index <= '0;
          window_full <= 1'b0;
        end else begin
          write_index      <= index_next;
          slot_valid[slot] <= 1'b1;
          if (wrap) begin
            window_full <= 1'b1;
          end
        end
      end
      if (accept && q_data.kind == JOB_FIT) begin
        fit_busy <= 1'b1;
      end else if (fit_done) begin
        fit_busy <= 1'b0;
      end
    end
  end

  // The rings must not change under a fit in progress.
  a_hold_during_fit: assert property (@(posedge clk) disable iff (rst)
    (accept && q_data.kind == JOB_FIT) |=> !in_ready)
    else $error("front accepted a word while a fit was pending");

endmodule

/* rtl/core/swld_back.sv */
// Back end: pair sums over the window, scaling and four parallel long
// divisions, then the output register. Depends on swld_pkg.
module swld_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 q_empty,
  output logic                                 q_pop,
  input  swld_pkg::job_t                       q_data,
  input  logic [swld_pkg::MAX_WINDOW-1:0]      slot_valid,
  output logic [swld_pkg::SLOT_W-1:0]          raddr_a,
  output logic [swld_pkg::SLOT_W-1:0]          raddr_b,
  input  logic [swld_pkg::TIME_W-1:0]          time_a,
  input  logic [swld_pkg::TIME_W-1:0]          time_b,
  input  logic [swld_pkg::ROW_W-1:0]           row_a,
  input  logic [swld_pkg::ROW_W-1:0]           row_b,
  output logic                                 fit_done,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 valid_res,
  output logic                                 zero_span,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_0,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_1,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_2,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_3
);
  import swld_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ORIGIN, S_ORIGIN_CAP, S_PAIRS, S_DRAIN,
    S_MUL0, S_MUL1, S_LOAD, S_DIV, S_EMIT
  } state_t;

  state_t             state;
  logic [LEN_W-1:0]   len;
  logic [SLOT_W-1:0]  pi;
  logic [SLOT_W-1:0]  pj;
  logic [SLOT_W-1:0]  pi_d;
  logic [SLOT_W-1:0]  pj_d;
  logic               v1;
  logic               v2;
  logic [TIME_W-1:0]  t_org;
  logic [SQ_W-1:0]    sq;
  logic signed [PR_W-1:0]  pr  [CHANNELS];
  logic [DEN_W-1:0]        den;
  logic signed [NUM_W-1:0] num [CHANNELS];
  logic                    neg [CHANNELS];
  logic [PP_W-1:0]         pl  [CHANNELS];
  logic [PP_W-1:0]         ph  [CHANNELS];
  logic [REM_W-1:0]        rem [CHANNELS];
  logic [Q_W-1:0]          quo [CHANNELS];
  logic [DSH_W-1:0]        dsh;
  logic [CNT_W-1:0]        div_cnt;
  logic                    res_zero;

  logic [TIME_W-1:0]         rel_i;
  logic [TIME_W-1:0]         rel_j;
  logic signed [TIME_W:0]    dt;
  logic [TIME_W-1:0]         ad;
  logic signed [SAMPLE_W:0]  dx  [CHANNELS];
  logic [NUM_W-1:0]          mag [CHANNELS];
  logic [HALF_W-1:0]         mul_in [CHANNELS];
  logic [PP_W-1:0]           prod [CHANNELS];
  logic [PROD_W-1:0]         pfull [CHANNELS];
  logic [SLOPE_W-1:0]        slope_v [CHANNELS];
  logic                      out_free;

  function automatic logic [SLOPE_W-1:0] saturate(input logic n, input logic [Q_W-1:0] q);
    logic big;
    big = q[Q_W-1] | q[Q_W-2];
    if (n) begin
      saturate = big ? {1'b1, {(SLOPE_W-1){1'b0}}} : -q[SLOPE_W-1:0];
    end else begin
      saturate = big ? {1'b0, {(SLOPE_W-1){1'b1}}} : q[SLOPE_W-1:0];
    end
  endfunction

  assign raddr_a  = pi;
  assign raddr_b  = pj;
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty &&
                    (q_data.kind == JOB_FIT || out_free);

  always_comb begin
    rel_i = (slot_valid[pi_d] ? time_a : '0) - t_org;
    rel_j = (slot_valid[pj_d] ? time_b : '0) - t_org;
    dt    = $signed({1'b0, rel_i}) - $signed({1'b0, rel_j});
    ad    = dt[TIME_W] ? TIME_W'(-dt) : dt[TIME_W-1:0];
    for (int c = 0; c < CHANNELS; c++) begin
      dx[c] = (SAMPLE_W + 1)'($signed(slot_valid[pi_d] ? row_a[c*SAMPLE_W +: SAMPLE_W] : '0))
            - (SAMPLE_W + 1)'($signed(slot_valid[pj_d] ? row_b[c*SAMPLE_W +: SAMPLE_W] : '0));
      mag[c]    = num[c][NUM_W-1] ? NUM_W'(-num[c]) : NUM_W'(num[c]);
      mul_in[c] = (state == S_MUL0) ? mag[c][HALF_W-1:0] : mag[c][NUM_W-1:HALF_W];
      prod[c]   = PP_W'(mul_in[c]) * PP_W'(SLOPE_SCALE);
      pfull[c]  = PROD_W'(pl[c]) + (PROD_W'(ph[c]) << HALF_W);
      slope_v[c] = res_zero ? '0 : saturate(neg[c], quo[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      v1        <= 1'b0;
      v2        <= 1'b0;
      fit_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      fit_done <= 1'b0;
      v1       <= (state == S_PAIRS);
      v2       <= v1;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      // pair pipeline: read, multiply, accumulate
      pi_d <= pi;
      pj_d <= pj;
      if (v1) begin
        sq <= SQ_W'(ad) * SQ_W'(ad);
        for (int c = 0; c < CHANNELS; c++) begin
          pr[c] <= PR_W'(dt) * PR_W'(dx[c]);
        end
      end
      if (v2) begin
        den <= den + DEN_W'(sq);
        for (int c = 0; c < CHANNELS; c++) begin
          num[c] <= num[c] + NUM_W'(pr[c]);
        end
      end

      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            if (q_data.kind == JOB_FIT) begin
              len <= q_data.len;
              pi  <= q_data.oldest;
              den <= '0;
              for (int c = 0; c < CHANNELS; c++) begin
                num[c] <= '0;
              end
              state <= S_ORIGIN;
            end else begin
              out_valid <= 1'b1;
              valid_res <= 1'b0;
              zero_span <= 1'b0;
              slope_0   <= '0;
              slope_1   <= '0;
              slope_2   <= '0;
              slope_3   <= '0;
            end
          end
        end
        S_ORIGIN: begin
          state <= S_ORIGIN_CAP;
        end
        S_ORIGIN_CAP: begin
          t_org <= slot_valid[pi] ? time_a : '0;
          pi    <= '0;
          pj    <= SLOT_W'(1);
          state <= S_PAIRS;
        end
        S_PAIRS: begin
          // walk the upper triangle of pairs, one pair a cycle
          if (LEN_W'(pj) == len - LEN_W'(1)) begin
            if (LEN_W'(pi) == len - LEN_W'(2)) begin
              state <= S_DRAIN;
            end else begin
              pi <= pi + SLOT_W'(1);
              pj <= pi + SLOT_W'(2);
            end
          end else begin
            pj <= pj + SLOT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            res_zero <= (den == '0);
            state    <= (den == '0) ? S_EMIT : S_MUL0;
          end
        end
        S_MUL0: begin
          for (int c = 0; c < CHANNELS; c++) begin
            neg[c] <= num[c][NUM_W-1];
            pl[c]  <= prod[c];
          end
          state <= S_MUL1;
        end
        S_MUL1: begin
          for (int c = 0; c < CHANNELS; c++) begin
            ph[c] <= prod[c];
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          // round to nearest: (2p + d) / 2d
          for (int c = 0; c < CHANNELS; c++) begin
            rem[c] <= {pfull[c], 1'b0} + REM_W'(den);
            quo[c] <= '0;
          end
          dsh     <= DSH_W'(den) << (SLOPE_W + 1);
          div_cnt <= '0;
          state   <= S_DIV;
        end
        S_DIV: begin
          for (int c = 0; c < CHANNELS; c++) begin
            if (DSH_W'(rem[c]) >= dsh) begin
              rem[c] <= rem[c] - dsh[REM_W-1:0];
              quo[c] <= {quo[c][Q_W-2:0], 1'b1};
            end else begin
              quo[c] <= {quo[c][Q_W-2:0], 1'b0};
            end
          end
          dsh     <= dsh >> 1;
          div_cnt <= div_cnt + CNT_W'(1);
          if (div_cnt == CNT_W'(Q_W - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            valid_res <= 1'b1;
            zero_span <= res_zero;
            slope_0   <= slope_v[0];
            slope_1   <= slope_v[1];
            slope_2   <= slope_v[2];
            slope_3   <= slope_v[3];
            fit_done  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_zero_has_valid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_span) |-> valid_res)
    else $error("zero_span raised without valid_res");

  a_blank_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !valid_res) |->
      (slope_0 == '0 && slope_1 == '0 && slope_2 == '0 && slope_3 == '0))
    else $error("blank word carries a non-zero slope");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_cnt < CNT_W'(Q_W)))
    else $error("divider ran past its last step");

  a_done_from_emit: assert property (@(posedge clk) disable iff (rst)
    fit_done |-> ($past(state) == S_EMIT))
    else $error("fit_done outside the emit step");

endmodule

/* rtl/core/sliding_window_lsq_derivative.sv */
// Top level of the sliding-window least-squares slope estimator.
// Depends on swld_pkg, swld_ram, swld_queue, swld_front and swld_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per sample set, carrying a
//   timestamp in microseconds and four Q1.14 channel values, or a restart
//   flag that clears the window index and full mark without storing.
//   Output channel (out_valid/out_ready): exactly one word per input word,
//   in order. Until the window has filled the word is all zeros; after
//   that it carries the least-squares slope of each channel in units per
//   second with 16 fraction bits, rounded and saturated. zero_span marks a
//   window whose timestamps are all equal (slopes then zero).
//   Configuration (cfg_valid/cfg_ready, window_len): window length, clamped
//   to 2..8; write it only while the block is idle. Reset value is 3.
// Timing:
//   A word that needs no fit passes through the job queue to the output
//   register. A fit for window length L reads the origin timestamp, then
//   walks the L*(L-1)/2 sample pairs, one pair per cycle, through the
//   two-port ring read, scales, and runs 33 steps of the four parallel
//   dividers; it skips both when all timestamps are equal.
//   While a fit is pending no further word is accepted, since the rings
//   must hold still under it; the next word is taken once fit_done, raised
//   as the fitted word enters the output register, has cleared fit_busy.
// Reset clears the rings' valid marks, index, full mark and queue at once;
// slots never written read as zero. A stalled receiver holds the output
// word; the two-entry queue accepts words that need no fit until it is full.
module sliding_window_lsq_derivative (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [swld_pkg::LEN_W-1:0]           window_len,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 restart,
  input  logic [swld_pkg::TIME_W-1:0]          sample_time,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [swld_pkg::SAMPLE_W-1:0] sample_3,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 valid_res,
  output logic                                 zero_span,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_0,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_1,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_2,
  output logic signed [swld_pkg::SLOPE_W-1:0]  slope_3
);
  import swld_pkg::*;

  // job queue between front and back
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_empty;
  job_t  q_in;
  job_t  q_out;

  // ring write side (front) and read side (back)
  logic                  ring_we;
  logic [SLOT_W-1:0]     ring_waddr;
  logic [TIME_W-1:0]     time_wdata;
  logic [ROW_W-1:0]      row_wdata;
  logic [SLOT_W-1:0]     raddr_a;
  logic [SLOT_W-1:0]     raddr_b;
  logic [TIME_W-1:0]     time_a;
  logic [TIME_W-1:0]     time_b;
  logic [ROW_W-1:0]      row_a;
  logic [ROW_W-1:0]      row_b;
  logic [MAX_WINDOW-1:0] slot_valid;
  logic                  fit_done;

  swld_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .window_len  (window_len),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .restart     (restart),
    .sample_time (sample_time),
    .sample_0    (sample_0),
    .sample_1    (sample_1),
    .sample_2    (sample_2),
    .sample_3    (sample_3),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in),
    .fit_done    (fit_done),
    .ring_we     (ring_we),
    .ring_waddr  (ring_waddr),
    .time_wdata  (time_wdata),
    .row_wdata   (row_wdata),
    .slot_valid  (slot_valid)
  );

  swld_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  // timestamp ring: one entry per slot
  swld_ram #(.WIDTH(TIME_W), .DEPTH(MAX_WINDOW)) u_time_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (time_wdata),
    .raddr_a (raddr_a),
    .rdata_a (time_a),
    .raddr_b (raddr_b),
    .rdata_b (time_b)
  );

  // sample ring: one row of all channels per slot
  swld_ram #(.WIDTH(ROW_W), .DEPTH(MAX_WINDOW)) u_sample_ring (
    .clk     (clk),
    .we      (ring_we),
    .waddr   (ring_waddr),
    .wdata   (row_wdata),
    .raddr_a (raddr_a),
    .rdata_a (row_a),
    .raddr_b (raddr_b),
    .rdata_b (row_b)
  );

  swld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .q_data     (q_out),
    .slot_valid (slot_valid),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .time_a     (time_a),
    .time_b     (time_b),
    .row_a      (row_a),
    .row_b      (row_b),
    .fit_done   (fit_done),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .valid_res  (valid_res),
    .zero_span  (zero_span),
    .slope_0    (slope_0),
    .slope_1    (slope_1),
    .slope_2    (slope_2),
    .slope_3    (slope_3)
  );

endmodule
